@@ sv/quadratic_calibrate_moving_average_core_assert.svh @@
// assertion macros for the calibrate and average core
`ifndef QUADRATIC_CALIBRATE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define QUADRATIC_CALIBRATE_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define QCMA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qcma assertion failed");

// next-cycle implication
`define QCMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qcma assertion failed");

`endif

@@ sv/qcma_pkg.sv @@
package qcma_pkg;

  localparam int VAL_W     = 48;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int RAW_W     = 16;
  localparam int WIDE_W    = 66;
  localparam int DIV_BITS  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_ENABLE = 2'd3;

  localparam logic signed [COEF_W-1:0] COEF_LINEAR_RESET = 32'sd65536;

  typedef struct packed {
    logic [RAW_W-1:0] raw_count;
    logic             record_last;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] filtered_value;
    logic                    record_end;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_INNER,
    ST_MUL,
    ST_PROD,
    ST_CAL,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // clamp a wide signed value to the 48-bit output range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VAL_W:0] top;
    top = v[WIDE_W-1:VAL_W-1];
    if (top == '0 || top == '1) begin
      sat_val = v[VAL_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ sv/quadratic_calibrate_moving_average_core.sv @@
// Calibrates each raw count as offset + x*(linear + x*square) in signed Q15.16
// coefficients, giving a saturated Q31.16 value, and optionally replaces it by the
// boxcar mean of the last AVG_DEPTH calibrated values (sum over the samples seen so
// far, divided by their count, truncated toward zero). One item is in work at a time;
// the next item is accepted as soon as the previous result sits in the output
// register. Direct mode works by Horner steps on a 17x32 multiplier and a split
// 17x48 multiply. Averaging mode then does a read-modify-write of the history ring
// memory followed by a 4-bit-per-cycle divide by the fill count. The ring needs no
// clearing pass after reset: until it has wrapped once the fill count marks the slot
// being overwritten as empty. Configuration must be written only while the core is
// idle; the core itself does not enforce this.
module quadratic_calibrate_moving_average_core #(
  parameter int AVG_DEPTH   = 44,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  qcma_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output qcma_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [qcma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qcma_pkg::CFG_W-1:0]          cfg_wdata
);

`include "quadratic_calibrate_moving_average_core_assert.svh"

  localparam int VAL_W     = qcma_pkg::VAL_W;
  localparam int COEF_W    = qcma_pkg::COEF_W;
  localparam int WIDE_W    = qcma_pkg::WIDE_W;
  localparam int DIV_BITS  = qcma_pkg::DIV_BITS;
  localparam int CNT_W     = $clog2(AVG_DEPTH + 1);
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int TOT_W     = VAL_W + CNT_W;
  localparam int DIV_ITERS = (TOT_W + DIV_BITS - 1) / DIV_BITS;
  localparam int QW        = DIV_ITERS * DIV_BITS;
  localparam int ITER_W    = $clog2(DIV_ITERS);
  localparam int RW        = CNT_W + 1;
  localparam int SQ_W      = SAMPLE_BITS + 1 + COEF_W;
  localparam int LO_W      = SAMPLE_BITS + 32;
  localparam int HI_W      = SAMPLE_BITS + 1 + (VAL_W - 32);
  localparam int PROD_W    = 64;

  qcma_pkg::state_t state_r, state_nxt;

  logic signed [COEF_W-1:0] coef_off_r;
  logic signed [COEF_W-1:0] coef_lin_r;
  logic signed [COEF_W-1:0] coef_sq_r;
  logic                     avg_en_r;

  logic [SAMPLE_BITS-1:0]   x_r;
  logic                     last_r;
  logic signed [SQ_W-1:0]   prod_sq_r;
  logic signed [VAL_W-1:0]  inner_r;
  logic [LO_W-1:0]          part_lo_r;
  logic signed [HI_W-1:0]   part_hi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  y_r;
  logic signed [VAL_W-1:0]  y_c;
  logic signed [VAL_W-1:0]  res_r;

  logic signed [VAL_W-1:0]  ring_mem [AVG_DEPTH];
  logic signed [VAL_W-1:0]  rd_data_r;
  logic signed [VAL_W-1:0]  old_c;
  logic signed [TOT_W-1:0]  total_r;
  logic [CNT_W-1:0]         fill_r;
  logic [SLOT_W-1:0]        slot_r;
  logic                     full_c;

  logic [TOT_W-1:0]         mag_c;
  logic [QW-1:0]            dq_r;
  logic [QW-1:0]            dq_c;
  logic [RW-1:0]            rem_r;
  logic [RW-1:0]            rem_c;
  logic                     neg_r;
  logic [ITER_W-1:0]        iter_r;
  logic signed [QW:0]       quo_c;

  logic                     mem_we;
  logic                     out_load;
  logic                     out_valid_r;
  qcma_pkg::out_t           out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_off_r <= '0;
      coef_lin_r <= qcma_pkg::COEF_LINEAR_RESET;
      coef_sq_r  <= '0;
      avg_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        qcma_pkg::CFG_COEF_OFFSET:    coef_off_r <= $signed(cfg_wdata[COEF_W-1:0]);
        qcma_pkg::CFG_COEF_LINEAR:    coef_lin_r <= $signed(cfg_wdata[COEF_W-1:0]);
        qcma_pkg::CFG_COEF_SQUARE:    coef_sq_r  <= $signed(cfg_wdata[COEF_W-1:0]);
        qcma_pkg::CFG_AVERAGE_ENABLE: avg_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qcma_pkg::ST_IDLE:   if (in_valid) state_nxt = qcma_pkg::ST_MUL_SQ;
      qcma_pkg::ST_MUL_SQ: state_nxt = qcma_pkg::ST_INNER;
      qcma_pkg::ST_INNER:  state_nxt = qcma_pkg::ST_MUL;
      qcma_pkg::ST_MUL:    state_nxt = qcma_pkg::ST_PROD;
      qcma_pkg::ST_PROD:   state_nxt = qcma_pkg::ST_CAL;
      qcma_pkg::ST_CAL:    state_nxt = avg_en_r ? qcma_pkg::ST_ACC : qcma_pkg::ST_OUT;
      qcma_pkg::ST_ACC:    state_nxt = qcma_pkg::ST_LOAD;
      qcma_pkg::ST_LOAD:   state_nxt = qcma_pkg::ST_DIV;
      qcma_pkg::ST_DIV: begin
        if (iter_r == ITER_W'(DIV_ITERS - 1)) state_nxt = qcma_pkg::ST_FIN;
      end
      qcma_pkg::ST_FIN:    state_nxt = qcma_pkg::ST_OUT;
      qcma_pkg::ST_OUT:    if (out_load) state_nxt = qcma_pkg::ST_IDLE;
      default:             state_nxt = qcma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      qcma_pkg::ST_IDLE: in_stall = 1'b0;
      qcma_pkg::ST_ACC:  mem_we   = 1'b1;
      qcma_pkg::ST_OUT:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign y_c    = qcma_pkg::sat_val(WIDE_W'(coef_off_r) + WIDE_W'(prod_r));
  assign full_c = (fill_r == CNT_W'(AVG_DEPTH));
  assign old_c  = full_c ? rd_data_r : '0;
  assign mag_c  = total_r[TOT_W-1] ? TOT_W'(-total_r) : TOT_W'(total_r);
  assign quo_c  = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  // restoring divide, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_c = rem_r;
    dq_c  = dq_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      rem_c = {rem_c[RW-2:0], dq_c[QW-1]};
      dq_c  = {dq_c[QW-2:0], 1'b0};
      if (rem_c >= RW'(fill_r)) begin
        rem_c    = rem_c - RW'(fill_r);
        dq_c[0]  = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qcma_pkg::ST_IDLE;
      total_r     <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        total_r <= total_r - TOT_W'(old_c) + TOT_W'(y_r);
        fill_r  <= full_c ? fill_r : fill_r + CNT_W'(1);
        slot_r  <= (slot_r == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[slot_r] <= y_r;
    end
    rd_data_r <= ring_mem[slot_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      qcma_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_r    <= in_data.raw_count[SAMPLE_BITS-1:0];
          last_r <= in_data.record_last;
        end
      end
      qcma_pkg::ST_MUL_SQ: prod_sq_r <= $signed({1'b0, x_r}) * coef_sq_r;
      qcma_pkg::ST_INNER: begin
        inner_r <= qcma_pkg::sat_val(WIDE_W'(coef_lin_r) + WIDE_W'(prod_sq_r));
      end
      qcma_pkg::ST_MUL: begin
        part_lo_r <= x_r * inner_r[31:0];
        part_hi_r <= $signed({1'b0, x_r}) * $signed(inner_r[VAL_W-1:32]);
      end
      qcma_pkg::ST_PROD: prod_r <= $signed((PROD_W'(part_hi_r) << 32) + PROD_W'(part_lo_r));
      qcma_pkg::ST_CAL: begin
        y_r   <= y_c;
        res_r <= y_c;
      end
      qcma_pkg::ST_LOAD: begin
        neg_r  <= total_r[TOT_W-1];
        dq_r   <= QW'(mag_c);
        rem_r  <= '0;
        iter_r <= '0;
      end
      qcma_pkg::ST_DIV: begin
        dq_r   <= dq_c;
        rem_r  <= rem_c;
        iter_r <= iter_r + ITER_W'(1);
      end
      qcma_pkg::ST_FIN: res_r <= qcma_pkg::sat_val(WIDE_W'(quo_c));
      default: ;
    endcase
    if (out_load) begin
      out_data_r.filtered_value <= res_r;
      out_data_r.record_end     <= last_r;
    end
  end

  `QCMA_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(AVG_DEPTH))
  `QCMA_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_r == qcma_pkg::ST_MUL_SQ)
  `QCMA_ASSERT_IMPL(a_ring_write_avg, clk, rst_n, mem_we, avg_en_r)
  `QCMA_ASSERT_NEXT(a_out_load, clk, rst_n, out_load, out_valid_r && out_data_r.record_end == $past(last_r))

endmodule
